@@ design/can_rx_filter_mailbox_fifo_defines.svh @@
// Assertion macros for the CAN receive filter block
`ifndef CAN_RX_FILTER_MAILBOX_FIFO_DEFINES_SVH
`define CAN_RX_FILTER_MAILBOX_FIFO_DEFINES_SVH
// implication checked on every clock edge outside reset
`define CRF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication checked outside reset
`define CRF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ design/crf_pkg.sv @@
// Types and constants shared by the CAN receive filter block
package crf_pkg;
    localparam int NUM_OBJECTS_DEF = 16;
    localparam int FIFO_DEPTH_DEF  = 8;
    localparam int ID_W            = 29;
    localparam int STD_W           = 11;
    localparam logic [ID_W-1:0] ID_MASK = 29'h1FFF_FFFF;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 29;

    localparam logic [CFG_IDX_W-1:0] CFG_BUS_OPEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STD_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXT_MASK = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_MASK = 2'd3;

    localparam logic [2:0] REQ_CONFIG = 3'd0;
    localparam logic [2:0] REQ_CLOSE  = 3'd1;
    localparam logic [2:0] REQ_CLEAR  = 3'd2;
    localparam logic [2:0] REQ_FRAME  = 3'd3;
    localparam logic [2:0] REQ_POP    = 3'd4;
    localparam logic [2:0] REQ_CHANGE = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_OBJ0  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_READ,
        S_DATA,
        S_EXEC,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [2:0]      req_type;
        logic [3:0]      obj_index;
        logic [ID_W-1:0] frame_id;
        logic            frame_ext;
        logic [3:0]      frame_dlc;
        logic [63:0]     frame_data;
        logic [31:0]     rx_time;
        logic [ID_W-1:0] filter_id;
        logic            filter_ext;
        logic [3:0]      obj_depth;
    } req_t;

    typedef struct packed {
        logic            msg_valid;
        logic [ID_W-1:0] msg_id;
        logic            msg_ext;
        logic [3:0]      msg_dlc;
        logic [63:0]     msg_data;
        logic [31:0]     msg_time;
        logic [3:0]      obj_count;
        logic [15:0]     match_mask;
        logic [1:0]      status;
    } rsp_t;

    function automatic logic [63:0] keep_bytes(input logic [63:0] d, input logic [3:0] dlc);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (b < dlc)
            begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return d & m;
    endfunction
endpackage

@@ design/crf_if.sv @@
// Valid/ready channel interfaces for requests and results
interface crf_req_if import crf_pkg::*; ();
    logic valid;
    logic ready;
    req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface crf_rsp_if import crf_pkg::*; ();
    logic valid;
    logic ready;
    rsp_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ design/crf_store.sv @@
// Message store: three memories with one write and one registered read port
module crf_store import crf_pkg::*; #(
    parameter int DEPTH = NUM_OBJECTS_DEF * FIFO_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [29:0]              wid_ext,
    input  logic [63:0]              wdata,
    input  logic [35:0]              wdlc_time,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [29:0]              rid_ext,
    output logic [63:0]              rdata,
    output logic [35:0]              rdlc_time
);
    logic [29:0] mem_id [DEPTH];
    logic [63:0] mem_data [DEPTH];
    logic [35:0] mem_dt [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_id[waddr]   <= wid_ext;
            mem_data[waddr] <= wdata;
            mem_dt[waddr]   <= wdlc_time;
        end
        rid_ext   <= mem_id[raddr];
        rdata     <= mem_data[raddr];
        rdlc_time <= mem_dt[raddr];
    end
endmodule

@@ design/can_rx_filter_mailbox_fifo.sv @@
// CAN receive acceptance filter with message objects and per-object ring buffers
//
// Channels: req (sink) takes one request per transaction; rsp (source) returns
// exactly one result per request. cfg_we/cfg_index/cfg_data write the four
// registers (bus open, standard mask, extended mask, last-object mask); the user
// must write them only while idle, as the block itself does not enforce this.
// One sequencer walks the objects with a single shared mask-and-compare unit.
// A frame takes one scan step per object plus a write step for each matching
// object stored on the fly; a frame on a closed bus goes straight to the result;
// a pop uses the registered store read port; other requests pass an execute state.
// The request side is not ready while a request is in progress or its result
// waits. If rsp is stalled the result register holds and no new request is taken.
// Reset closes the bus, deactivates all objects and clears pointers; the
// message store is not cleared, as only written entries are ever read.
`include "can_rx_filter_mailbox_fifo_defines.svh"
module can_rx_filter_mailbox_fifo import crf_pkg::*; #(
    parameter int NUM_OBJECTS = NUM_OBJECTS_DEF,
    parameter int FIFO_DEPTH  = FIFO_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    crf_req_if.sink               req,
    crf_rsp_if.source             rsp
);
    localparam int OW = $clog2(NUM_OBJECTS);
    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int SD = NUM_OBJECTS * FIFO_DEPTH;
    localparam int AW = $clog2(SD);
    localparam logic [CW-1:0] FD = CW'(FIFO_DEPTH);

    logic            bus_open_reg;
    logic [STD_W-1:0] std_mask_reg;
    logic [ID_W-1:0] ext_mask_reg, last_mask_reg;

    logic [ID_W-1:0] filt_reg [NUM_OBJECTS];
    logic            fext_reg [NUM_OBJECTS];
    logic [CW-1:0]   size_reg [NUM_OBJECTS];
    logic [CW-1:0]   fill_reg [NUM_OBJECTS];
    logic [PW-1:0]   rd_reg [NUM_OBJECTS];
    logic [PW-1:0]   wr_reg [NUM_OBJECTS];

    state_t state_reg, state_next;
    req_t   q_reg;
    rsp_t   out_reg, out_next;
    logic [OW:0] k_reg;
    logic [15:0] match_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_open_reg  <= 1'b0;
            std_mask_reg  <= '0;
            ext_mask_reg  <= '0;
            last_mask_reg <= ID_MASK;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BUS_OPEN:  bus_open_reg  <= cfg_data[0];
                CFG_STD_MASK:  std_mask_reg  <= cfg_data[STD_W-1:0];
                CFG_EXT_MASK:  ext_mask_reg  <= cfg_data;
                CFG_LAST_MASK: last_mask_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // decoded request
    logic [OW-1:0] o;
    logic          inrange, obj0;
    logic [CW-1:0] depth_sat;
    logic [3:0]    dlc_sat;
    always_comb
    begin
        o         = OW'(q_reg.obj_index);
        inrange   = ({28'd0, q_reg.obj_index} < 32'(NUM_OBJECTS));
        obj0      = (q_reg.obj_index == 4'd0);
        depth_sat = (32'(q_reg.obj_depth) > 32'(FIFO_DEPTH)) ? FD : CW'(q_reg.obj_depth);
        dlc_sat   = (q_reg.frame_dlc > 4'd8) ? 4'd8 : q_reg.frame_dlc;
    end

    // shared compare unit on object k
    logic [OW-1:0]   k;
    logic [ID_W-1:0] cmask;
    logic            hit;
    always_comb
    begin
        k     = k_reg[OW-1:0];
        cmask = q_reg.frame_ext ? ext_mask_reg : {{(ID_W-STD_W){1'b0}}, std_mask_reg};
        if (32'(k) == NUM_OBJECTS - 1)
        begin
            cmask = cmask & last_mask_reg;
        end
        hit = (size_reg[k] != '0) && (fext_reg[k] == q_reg.frame_ext) &&
              ((q_reg.frame_id & cmask) == (filt_reg[k] & cmask));
    end

    // store ports
    logic          st_we;
    logic [AW-1:0] st_waddr, st_raddr;
    logic [29:0]   r_id_ext;
    logic [63:0]   r_data;
    logic [35:0]   r_dt;
    logic [PW-1:0] wr_inc;
    always_comb
    begin
        st_we    = (state_reg == S_WRITE);
        st_waddr = AW'(32'(k) * FIFO_DEPTH + 32'(wr_reg[k]));
        st_raddr = AW'(32'(o) * FIFO_DEPTH + 32'(rd_reg[o]));
        wr_inc   = (32'(wr_reg[k]) + 1 >= 32'(size_reg[k])) ? '0 : PW'(32'(wr_reg[k]) + 1);
    end

    crf_store #(.DEPTH(SD)) u_store (
        .clk       (clk),
        .we        (st_we),
        .waddr     (st_waddr),
        .wid_ext   ({q_reg.frame_ext, q_reg.frame_id}),
        .wdata     (keep_bytes(q_reg.frame_data, dlc_sat)),
        .wdlc_time ({dlc_sat, q_reg.rx_time}),
        .raddr     (st_raddr),
        .rid_ext   (r_id_ext),
        .rdata     (r_data),
        .rdlc_time (r_dt)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (req.valid) state_next = (req.payload.req_type == REQ_FRAME) ? S_SCAN
                                   : (req.payload.req_type == REQ_POP) ? S_READ : S_EXEC;
            S_SCAN:  if (!bus_open_reg || 32'(k_reg) >= NUM_OBJECTS) state_next = S_OUT;
                     else if (hit) state_next = S_WRITE;
            S_WRITE: state_next = S_SCAN;
            S_READ:  state_next = S_DATA;
            S_DATA:  state_next = S_OUT;
            S_EXEC:  state_next = S_OUT;
            S_OUT:   if (rsp.ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = (state_reg == S_OUT);
    assign rsp.payload = out_reg;

    logic pop_ok;
    assign pop_ok = !obj0 && inrange && size_reg[o] != '0 && fill_reg[o] != '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            match_reg <= '0;
            for (int i = 0; i < NUM_OBJECTS; i++)
            begin
                filt_reg[i] <= '0;
                fext_reg[i] <= 1'b0;
                size_reg[i] <= '0;
                fill_reg[i] <= '0;
                rd_reg[i]   <= '0;
                wr_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    k_reg     <= (OW+1)'(1);
                    match_reg <= '0;
                    if (req.valid)
                    begin
                        q_reg <= req.payload;
                    end
                end
                S_SCAN:
                begin
                    if (!hit || !bus_open_reg || 32'(k_reg) >= NUM_OBJECTS)
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                S_WRITE:
                begin
                    wr_reg[k] <= wr_inc;
                    if (fill_reg[k] >= size_reg[k])
                    begin
                        rd_reg[k] <= wr_inc;
                    end
                    else
                    begin
                        fill_reg[k] <= fill_reg[k] + 1'b1;
                    end
                    if (32'(k) < 16)
                    begin
                        match_reg[4'(k)] <= 1'b1;
                    end
                    k_reg <= k_reg + 1'b1;
                end
                S_READ: ;
                S_DATA:
                begin
                    if (pop_ok)
                    begin
                        rd_reg[o]   <= (32'(rd_reg[o]) + 1 >= 32'(size_reg[o])) ? '0
                                       : PW'(32'(rd_reg[o]) + 1);
                        fill_reg[o] <= fill_reg[o] - 1'b1;
                    end
                end
                S_OUT:
                begin
                    if (rsp.ready && inrange && !obj0)
                    begin
                        case (q_reg.req_type)
                            REQ_CONFIG:
                            begin
                                if (q_reg.obj_depth != 4'd0)
                                begin
                                    filt_reg[o] <= q_reg.filter_id;
                                    fext_reg[o] <= q_reg.filter_ext;
                                end
                                size_reg[o] <= depth_sat;
                                fill_reg[o] <= '0;
                                rd_reg[o]   <= '0;
                                wr_reg[o]   <= '0;
                            end
                            REQ_CLOSE, REQ_CLEAR:
                            begin
                                if (q_reg.req_type == REQ_CLOSE)
                                begin
                                    size_reg[o] <= '0;
                                end
                                fill_reg[o] <= '0;
                                rd_reg[o]   <= '0;
                                wr_reg[o]   <= '0;
                            end
                            REQ_CHANGE:
                            begin
                                if (size_reg[o] != '0)
                                begin
                                    filt_reg[o] <= q_reg.filter_id;
                                    fext_reg[o] <= q_reg.filter_ext;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    // result assembly; counts for configure/close/clear are known before update
    logic [CW-1:0] cnt;
    always_comb
    begin
        cnt = inrange ? fill_reg[o] : '0;
        if (inrange && !obj0 && (q_reg.req_type == REQ_CONFIG ||
            q_reg.req_type == REQ_CLOSE || q_reg.req_type == REQ_CLEAR))
        begin
            cnt = '0;
        end
    end

    always_comb
    begin
        out_next            = '0;
        out_next.obj_count  = 4'(cnt);
        out_next.match_mask = (q_reg.req_type == REQ_FRAME) ? match_reg : 16'd0;
        if ((q_reg.req_type == REQ_CONFIG && obj0 && q_reg.obj_depth != 4'd0) ||
            ((q_reg.req_type == REQ_POP || q_reg.req_type == REQ_CHANGE) && obj0))
        begin
            out_next.status = ST_OBJ0;
        end
        if (q_reg.req_type == REQ_POP && !obj0 && !pop_ok)
        begin
            out_next.status = ST_EMPTY;
        end
        if (q_reg.req_type == REQ_POP && pop_ok)
        begin
            out_next.msg_valid = 1'b1;
            out_next.msg_id    = r_id_ext[ID_W-1:0];
            out_next.msg_ext   = r_id_ext[29];
            out_next.msg_dlc   = r_dt[35:32];
            out_next.msg_time  = r_dt[31:0];
            out_next.msg_data  = keep_bytes(r_data, r_dt[35:32]);
            out_next.obj_count = 4'(fill_reg[o] - 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_next == S_OUT && state_reg != S_OUT)
        begin
            out_reg <= out_next;
        end
    end

    `CRF_ASSERT_IMP(a_ready_idle, req.ready, !rsp.valid, "request taken while result pending")
    `CRF_ASSERT_NXT(a_write_scan, state_reg == S_WRITE, state_reg == S_SCAN, "write not followed by scan")
    `CRF_ASSERT_IMP(a_fill_le_size, state_reg == S_WRITE, fill_reg[k] <= size_reg[k], "fill above size")
    `CRF_ASSERT_NXT(a_pop_path, state_reg == S_READ, state_reg == S_DATA, "pop read sequence broken")
endmodule

@@ verif/can_rx_filter_mailbox_fifo_tb.sv @@
// Self-checking testbench for the CAN receive filter with message object buffers
`timescale 1ns / 1ps
module can_rx_filter_mailbox_fifo_tb import crf_pkg::*;;

    localparam int OBJS  = 16;
    localparam int DEPTH = 8;
    localparam logic [2:0] REQ_NOP_A = 3'd6;
    localparam logic [2:0] REQ_NOP_B = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    crf_req_if req_ch ();
    crf_rsp_if rsp_ch ();

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int n_frames = 0;
    int n_pops = 0;

    can_rx_filter_mailbox_fifo u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    class filter_scoreboard;
        bit              bus_open;
        bit [STD_W-1:0]  std_mask;
        bit [ID_W-1:0]   ext_mask;
        bit [ID_W-1:0]   last_mask;
        bit [ID_W-1:0]   filter [OBJS];
        bit              fext [OBJS];
        bit [3:0]        size [OBJS];
        bit [3:0]        fill [OBJS];
        bit [2:0]        rd [OBJS];
        bit [2:0]        wr [OBJS];
        bit [ID_W-1:0]   slot_id [OBJS*DEPTH];
        bit              slot_ext [OBJS*DEPTH];
        bit [3:0]        slot_dlc [OBJS*DEPTH];
        bit [63:0]       slot_data [OBJS*DEPTH];
        bit [31:0]       slot_time [OBJS*DEPTH];
        rsp_t            expected_q [$];
        int              errors;
        int              checked;

        function new();
            bus_open = 1'b0;
            std_mask = '0;
            ext_mask = '0;
            last_mask = ID_MASK;
            for (int i = 0; i < OBJS; i++)
            begin
                filter[i] = '0;
                fext[i] = 1'b0;
                size[i] = '0;
                empty_obj(i);
            end
            errors = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_BUS_OPEN:  bus_open = v[0];
                CFG_STD_MASK:  std_mask = v[STD_W-1:0];
                CFG_EXT_MASK:  ext_mask = v;
                CFG_LAST_MASK: last_mask = v;
                default: ;
            endcase
        endfunction

        function void empty_obj(int o);
            fill[o] = '0;
            rd[o] = '0;
            wr[o] = '0;
        endfunction

        function bit [63:0] trim_data(bit [63:0] d, bit [3:0] dlc);
            bit [63:0] r;
            r = '0;
            for (int b = 0; b < 8; b++)
                if (b < dlc)
                    r[b*8 +: 8] = d[b*8 +: 8];
            return r;
        endfunction

        function bit [ID_W-1:0] mask_for(int o, bit x);
            bit [ID_W-1:0] m;
            m = x ? ext_mask : {{(ID_W-STD_W){1'b0}}, std_mask};
            if (o == OBJS - 1)
                m &= last_mask;
            return m;
        endfunction

        function void note_request(req_t r);
            rsp_t    e;
            bit [3:0] depth;
            bit [3:0] dlc;
            int       o;
            int       a;
            e = '0;
            o = r.obj_index;
            depth = (r.obj_depth > DEPTH) ? 4'(DEPTH) : r.obj_depth;
            dlc = (r.frame_dlc > 8) ? 4'd8 : r.frame_dlc;
            case (r.req_type)
                REQ_CONFIG:
                    if (o == 0 && depth != 0)
                        e.status = ST_OBJ0;
                    else if (o != 0)
                    begin
                        if (depth != 0)
                        begin
                            filter[o] = r.filter_id;
                            fext[o] = r.filter_ext;
                        end
                        size[o] = depth;
                        empty_obj(o);
                    end
                REQ_CLOSE:
                    if (o != 0)
                    begin
                        size[o] = '0;
                        empty_obj(o);
                    end
                REQ_CLEAR:
                    if (o != 0)
                        empty_obj(o);
                REQ_FRAME:
                    if (bus_open)
                        for (int k = 1; k < OBJS; k++)
                        begin
                            if (size[k] != 0 && fext[k] == r.frame_ext &&
                                ((r.frame_id ^ filter[k]) & mask_for(k, r.frame_ext)) == 0)
                            begin
                                a = k * DEPTH + wr[k];
                                wr[k] = 3'((wr[k] + 1) % size[k]);
                                if (fill[k] >= size[k])
                                    rd[k] = wr[k];
                                else
                                    fill[k]++;
                                slot_id[a] = r.frame_id;
                                slot_ext[a] = r.frame_ext;
                                slot_dlc[a] = dlc;
                                slot_data[a] = trim_data(r.frame_data, dlc);
                                slot_time[a] = r.rx_time;
                                e.match_mask[k] = 1'b1;
                            end
                        end
                REQ_POP:
                    if (o == 0)
                        e.status = ST_OBJ0;
                    else if (size[o] == 0 || fill[o] == 0)
                        e.status = ST_EMPTY;
                    else
                    begin
                        a = o * DEPTH + rd[o];
                        e.msg_valid = 1'b1;
                        e.msg_id = slot_id[a];
                        e.msg_ext = slot_ext[a];
                        e.msg_dlc = slot_dlc[a];
                        e.msg_data = trim_data(slot_data[a], slot_dlc[a]);
                        e.msg_time = slot_time[a];
                        rd[o] = 3'((rd[o] + 1) % size[o]);
                        fill[o]--;
                    end
                REQ_CHANGE:
                    if (o == 0)
                        e.status = ST_OBJ0;
                    else if (size[o] != 0)
                    begin
                        filter[o] = r.filter_id;
                        fext[o] = r.filter_ext;
                    end
                default: ;
            endcase
            e.obj_count = fill[o];
            expected_q.push_back(e);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
            errors++;
        endtask

        task check_result(rsp_t g);
            rsp_t e;
            if (expected_q.size() == 0)
            begin
                report("unexpected transaction", 64'(g.status), 64'(0));
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (g.msg_valid !== e.msg_valid)
                report("msg_valid", 64'(g.msg_valid), 64'(e.msg_valid));
            if (g.msg_id !== e.msg_id)
                report("msg_id", 64'(g.msg_id), 64'(e.msg_id));
            if (g.msg_ext !== e.msg_ext)
                report("msg_ext", 64'(g.msg_ext), 64'(e.msg_ext));
            if (g.msg_dlc !== e.msg_dlc)
                report("msg_dlc", 64'(g.msg_dlc), 64'(e.msg_dlc));
            if (g.msg_data !== e.msg_data)
                report("msg_data", g.msg_data, e.msg_data);
            if (g.msg_time !== e.msg_time)
                report("msg_time", 64'(g.msg_time), 64'(e.msg_time));
            if (g.obj_count !== e.obj_count)
                report("obj_count", 64'(g.obj_count), 64'(e.obj_count));
            if (g.match_mask !== e.match_mask)
                report("match_mask", 64'(g.match_mask), 64'(e.match_mask));
            if (g.status !== e.status)
                report("status", 64'(g.status), 64'(e.status));
        endtask
    endclass

    filter_scoreboard sb = new();

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_result(rsp_ch.payload);
            rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    task automatic write_regs(logic [28:0] open_v, logic [28:0] std_v,
                              logic [28:0] ext_v, logic [28:0] last_v);
        logic [28:0] vals [4];
        vals = '{open_v, std_v, ext_v, last_v};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data <= vals[i];
            @(posedge clk);
            sb.write_reg(CFG_IDX_W'(i), vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send(req_t r);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.payload <= r;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(r);
        if (r.req_type == REQ_FRAME) n_frames++;
        if (r.req_type == REQ_POP) n_pops++;
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic req_t make_req(logic [2:0] kind, logic [3:0] o);
        req_t r;
        r.req_type = kind;
        r.obj_index = o;
        r.frame_id = ID_W'($urandom);
        r.frame_ext = 1'($urandom);
        r.frame_dlc = 4'($urandom_range(0, 8));
        r.frame_data = {$urandom, $urandom};
        r.rx_time = $urandom;
        r.filter_id = ID_W'($urandom);
        r.filter_ext = 1'($urandom);
        r.obj_depth = 4'($urandom_range(1, 8));
        return r;
    endfunction

    function automatic req_t random_req();
        req_t       r;
        int         pick;
        logic [3:0] o;
        pick = $urandom_range(99);
        o = 4'($urandom_range(1, OBJS - 1));
        if (pick < 3)
            o = (pick == 0) ? 4'd0 : 4'($urandom_range(0, OBJS - 1));
        if (pick < 12)
        begin
            r = make_req(REQ_CONFIG, o);
            if ($urandom_range(9) == 0)
                r.obj_depth = 4'($urandom);
        end
        else if (pick < 16)
            r = make_req(($urandom_range(1) != 0) ? REQ_CLOSE : REQ_CLEAR, o);
        else if (pick < 52)
        begin
            r = make_req(REQ_FRAME, o);
            if ($urandom_range(9) == 0)
                r.frame_dlc = 4'($urandom);
            if (sb.size[o] != 0 && $urandom_range(9) < 7)
            begin
                r.frame_ext = sb.fext[o];
                r.frame_id = sb.filter[o] ^ (ID_W'($urandom) & ~sb.mask_for(o, sb.fext[o]));
                if (!sb.fext[o] && $urandom_range(1) != 0)
                    r.frame_id[ID_W-1:STD_W] = '0;
            end
        end
        else if (pick < 88)
            r = make_req(REQ_POP, o);
        else if (pick < 95)
            r = make_req(REQ_CHANGE, o);
        else
            r = make_req(3'($urandom), 4'($urandom_range(0, OBJS - 1)));
        return r;
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
        begin
            send(random_req());
            if (i == n / 2)
                drain();
        end
        drain();
    endtask

    initial
    begin
        req_t r;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bus still closed: frame ignored
        r = make_req(REQ_CONFIG, 1);
        r.filter_id = 29'h123; r.filter_ext = 1'b0;
        send(r);
        send(make_req(REQ_FRAME, 0));
        drain();
        write_regs(29'h1FFF_FFFF, 29'h1FFF_FFFF, 29'h1FFF_FFFF, 29'h1FFF_FFFF);

        r = make_req(REQ_CONFIG, 2);
        r.obj_depth = 4'd15; r.filter_id = 29'h1FFF_FFFF; r.filter_ext = 1'b1;
        send(r);
        r = make_req(REQ_CONFIG, 15);
        r.obj_depth = 4'd9; r.filter_id = 29'h1FFF_FFFF; r.filter_ext = 1'b1;
        send(r);
        send(make_req(REQ_CONFIG, 0));
        r = make_req(REQ_CONFIG, 0); r.obj_depth = 4'd0;
        send(r);
        send(make_req(REQ_POP, 0));
        send(make_req(REQ_CHANGE, 0));
        send(make_req(REQ_CLOSE, 0));
        send(make_req(REQ_CLEAR, 0));
        // overflow object 2 with extreme data, dlc above 8 and short dlc
        for (int i = 0; i < 10; i++)
        begin
            r = make_req(REQ_FRAME, 0);
            r.frame_id = 29'h1FFF_FFFF; r.frame_ext = 1'b1;
            r.frame_dlc = (i == 0) ? 4'd15 : ((i == 1) ? 4'd0 : 4'($urandom_range(1, 8)));
            r.frame_data = (i[0]) ? '0 : '1;
            r.rx_time = (i[0]) ? '0 : '1;
            send(r);
        end
        send(make_req(REQ_POP, 2));
        send(make_req(REQ_POP, 15));
        r = make_req(REQ_FRAME, 0);
        r.frame_id = 29'h123; r.frame_ext = 1'b0; r.frame_dlc = 4'd3; r.frame_data = '1;
        send(r);
        send(make_req(REQ_POP, 1));
        send(make_req(REQ_POP, 1));
        send(make_req(REQ_CHANGE, 7));
        send(make_req(REQ_CLOSE, 9));
        send(make_req(REQ_CLEAR, 2));
        send(make_req(REQ_NOP_A, 5));
        send(make_req(REQ_NOP_B, 15));
        r = make_req(REQ_CONFIG, 15); r.obj_depth = 4'd0;
        send(r);
        drain();

        snd_idle_pct = 10; rcv_idle_pct = 86;
        write_regs(29'h1, 29'h1FFF_F8F0, 29'h1FFF_FF00, 29'h0);
        random_phase(130);

        snd_idle_pct = 86; rcv_idle_pct = 10;
        write_regs(29'h1, 29'h0, 29'h0, 29'h1FFF_FFFF);
        random_phase(130);

        snd_idle_pct = 0; rcv_idle_pct = 0;
        write_regs(29'h1FFF_FFFF, 29'($urandom), 29'($urandom), 29'($urandom));
        random_phase(140);

        $display("Covered %0d transactions: %0d frames, %0d pops, across four register settings",
                 sb.checked, n_frames, n_pops);
        $display("with sender and receiver stalls in turn and one fully back-to-back phase.");
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Timeout with %0d results outstanding", sb.expected_q.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

@@ can_rx_filter_mailbox_fifo.f @@
+incdir+design
design/crf_pkg.sv
design/crf_if.sv
design/crf_store.sv
design/can_rx_filter_mailbox_fifo.sv
verif/can_rx_filter_mailbox_fifo_tb.sv
